/* hdl/vmwm_pkg.sv */
// Package: shared types, register indexes and binary32 arithmetic helpers.
package vmwm_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT  = 4'd0,
        CFG_TOTAL_COLS = 4'd1,
        CFG_FIRST_COL  = 4'd2,
        CFG_END_COL    = 4'd3
    } cfg_idx_t;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic        first;
        logic        emit;
        logic        last;
        logic [11:0] col;
    } ctl_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic [9:0]  exp;     // two's complement, biased sum of exponents
        logic [47:0] prod;
    } mul_b_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic [8:0]  ef;
        logic [23:0] m24;
        logic        g;
        logic        s;
    } mul_c_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic [7:0]  ex;
        logic [27:0] r;
    } add_e_t;

    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (x[i])
            begin
                pos = 6'(i);
            end
        end
        return 6'd47 - pos;
    endfunction

    function automatic logic [31:0] round_pack(input logic sign, input logic [8:0] ef,
                                               input logic [23:0] m24, input logic g,
                                               input logic s);
        logic inc;
        inc = g && (s || m24[0]);
        if (ef >= 9'd255)
        begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, {ef[7:0], m24[22:0]} + {30'd0, inc}};
    endfunction

    // Operand classification and raw mantissa product
    function automatic mul_b_t mul_pre(input logic [31:0] a, input logic [31:0] b);
        mul_b_t o;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0] ea, eb;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        o.sign = a[31] ^ b[31];
        o.spec = 1'b1;
        o.spec_val = 32'd0;
        if (a_nan)
        begin
            o.spec_val = a | QUIET_BIT;
        end
        else if (b_nan)
        begin
            o.spec_val = b | QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (a_zero && b_inf))
        begin
            o.spec_val = QNAN_DEFAULT;
        end
        else if (a_inf || b_inf)
        begin
            o.spec_val = {o.sign, 8'hFF, 23'd0};
        end
        else if (a_zero || b_zero)
        begin
            o.spec_val = {o.sign, 31'd0};
        end
        else
        begin
            o.spec = 1'b0;
        end
        o.exp  = {2'b00, ea} + {2'b00, eb} - 10'd127;
        o.prod = {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
        return o;
    endfunction

    // Normalize the product, denormalizing below the smallest exponent
    function automatic mul_c_t mul_norm(input mul_b_t b);
        mul_c_t o;
        logic [5:0] lz;
        logic signed [10:0] e11, sh, rs;
        logic [47:0] n;
        logic stk;
        lz  = lzc48(b.prod);
        e11 = signed'({b.exp[9], b.exp}) + 11'sd1 - signed'({5'd0, lz});
        stk = 1'b0;
        rs  = 11'sd0;
        if (e11 > 11'sd0)
        begin
            n = b.prod << lz;
            o.ef = e11[8:0];
        end
        else
        begin
            o.ef = 9'd0;
            sh = e11 + signed'({5'd0, lz}) - 11'sd1;
            if (sh >= 11'sd0)
            begin
                n = b.prod << sh[5:0];
            end
            else
            begin
                rs = -sh;
                if (rs >= 11'sd48)
                begin
                    n = 48'd0;
                    stk = |b.prod;
                end
                else
                begin
                    n = b.prod >> rs[5:0];
                    stk = |(b.prod & ~(48'hFFFF_FFFF_FFFF << rs[5:0]));
                end
            end
        end
        o.spec = b.spec;
        o.spec_val = b.spec_val;
        o.sign = b.sign;
        o.m24 = n[47:24];
        o.g = n[23];
        o.s = (|n[22:0]) | stk;
        return o;
    endfunction

    function automatic logic [31:0] mul_round(input mul_c_t c);
        if (c.spec)
        begin
            return c.spec_val;
        end
        return round_pack(c.sign, c.ef, c.m24, c.g, c.s);
    endfunction

    // x + y: specials, operand swap, alignment and raw add or subtract
    function automatic add_e_t add_align(input logic [31:0] x, input logic [31:0] y);
        add_e_t o;
        logic x_nan, y_nan, x_inf, y_inf, sub;
        logic [31:0] big, sml;
        logic [7:0] eb, es, d;
        logic [26:0] mb, ms0, ms;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        o.spec = 1'b1;
        o.spec_val = 32'd0;
        if (x_nan)
        begin
            o.spec_val = x | QUIET_BIT;
        end
        else if (y_nan)
        begin
            o.spec_val = y | QUIET_BIT;
        end
        else if (x_inf && y_inf && (x[31] != y[31]))
        begin
            o.spec_val = QNAN_DEFAULT;
        end
        else if (x_inf)
        begin
            o.spec_val = x;
        end
        else if (y_inf)
        begin
            o.spec_val = y;
        end
        else
        begin
            o.spec = 1'b0;
        end
        if (x[30:0] >= y[30:0])
        begin
            big = x;
            sml = y;
        end
        else
        begin
            big = y;
            sml = x;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        mb  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        ms0 = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        if (d >= 8'd27)
        begin
            ms = {26'd0, |ms0};
        end
        else
        begin
            ms = (ms0 >> d[4:0]) | {26'd0, |(ms0 & ~(27'h7FF_FFFF << d[4:0]))};
        end
        sub = x[31] ^ y[31];
        o.r = sub ? ({1'b0, mb} - {1'b0, ms}) : ({1'b0, mb} + {1'b0, ms});
        o.sign = (sub && (o.r == 28'd0)) ? 1'b0 : big[31];
        o.ex = eb;
        return o;
    endfunction

    function automatic logic [31:0] add_norm(input add_e_t e);
        logic [26:0] n;
        logic [8:0] ex9, lim, shl, lz9;
        if (e.spec)
        begin
            return e.spec_val;
        end
        if (e.r == 28'd0)
        begin
            return {e.sign, 31'd0};
        end
        ex9 = {1'b0, e.ex};
        if (e.r[27])
        begin
            n = {e.r[27:2], e.r[1] | e.r[0]};
            ex9 = ex9 + 9'd1;
        end
        else
        begin
            lz9 = {3'd0, lzc48({e.r[26:0], 21'd0})};
            lim = ex9 - 9'd1;
            shl = (lz9 < lim) ? lz9 : lim;
            n = e.r[26:0] << shl[4:0];
            ex9 = ex9 - shl;
        end
        return round_pack(e.sign, n[26] ? ex9 : 9'd0, n[26:3], n[2], |n[1:0]);
    endfunction

endpackage

/* hdl/vmwm_if.sv */
// Interfaces: element input, result output and configuration write channels.
interface vmwm_elem_if;
    logic        valid;
    logic        ready;
    logic [31:0] matrix_element;
    logic [31:0] vector_element;
    modport source(output valid, matrix_element, vector_element, input ready);
    modport sink(input valid, matrix_element, vector_element, output ready);
endinterface

interface vmwm_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] column_index;
    logic [31:0] result_value;
    logic        last_column;
    modport source(output valid, column_index, result_value, last_column, input ready);
    modport sink(input valid, column_index, result_value, last_column, output ready);
endinterface

interface vmwm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vmwm_pkg::CFG_IDX_W-1:0]   index;
    logic [vmwm_pkg::CFG_DATA_W-1:0]  data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hdl/vector_matrix_window_multiply.sv */
// Top level: windowed vector-times-matrix product, binary32, accumulators in RAM.
//
//  channel  | dir  | content                                      | accepted when
//  ---------+------+----------------------------------------------+---------------
//  elem     | in   | matrix_element, vector_element               | valid & ready
//  result   | out  | column_index, result_value, last_column      | valid & ready
//  cfg      | in   | index, data (row_count/total_cols/first/end) | valid & ready
//
// One element per cycle while no hazard or output stall holds the input. Stages:
// input register, multiply in three stages with the RAM read beside the last,
// add in two stages. An accumulator read waits while a write to the same column
// is still in the two add stages, so a total_cols of 1 or 2 inserts bubbles
// between elements. Reset clears control only; accumulators are loaded by row 0
// and need no clearing. Output stalls fill the pipeline first.
module vector_matrix_window_multiply #(
    parameter int MAX_COLS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    vmwm_elem_if.sink            elem,
    vmwm_result_if.source        result,
    vmwm_cfg_if.sink             cfg
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [16:0] MAXC = 17'(MAX_COLS);

    // configuration and stream position
    logic [15:0] row_count_reg, row_count_next;
    logic [12:0] total_cols_reg, total_cols_next;
    logic [12:0] first_col_reg, first_col_next;
    logic [12:0] end_col_reg, end_col_next;
    logic [15:0] row_pos_reg, row_pos_next;
    logic [12:0] col_pos_reg, col_pos_next;

    // pipeline valids
    logic va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    logic vd_reg, vd_next, ve_reg, ve_next, vo_reg, vo_next;

    // pipeline payload
    vmwm_pkg::ctl_t    a_ctl_reg, b_ctl_reg, c_ctl_reg, d_ctl_reg, e_ctl_reg;
    logic [AW-1:0]     a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg, e_idx_reg;
    logic [31:0]       a_mat_reg, a_vec_reg;
    vmwm_pkg::mul_b_t  b_mul_reg;
    vmwm_pkg::mul_c_t  c_mul_reg;
    logic [31:0]       d_prod_reg;
    vmwm_pkg::add_e_t  e_add_reg;
    logic [11:0]       o_col_reg;
    logic [31:0]       o_val_reg;
    logic              o_last_reg;

    logic [15:0] rows_eff;
    logic [16:0] cols_eff, hi, c17;
    logic        in_win, accept, accept_win;
    logic        adv_a, adv_b, adv_c, adv_d, fire_e, haz;
    vmwm_pkg::ctl_t   in_ctl;
    vmwm_pkg::add_e_t d_add;
    logic [31:0] e_sum;
    logic [31:0] ram_rdata;

    always_comb
    begin
        rows_eff = (row_count_reg == 16'd0) ? 16'd1 : row_count_reg;
        if (total_cols_reg == 13'd0)
        begin
            cols_eff = 17'd1;
        end
        else if ({4'd0, total_cols_reg} > MAXC)
        begin
            cols_eff = MAXC;
        end
        else
        begin
            cols_eff = {4'd0, total_cols_reg};
        end
        hi  = ({4'd0, end_col_reg} < cols_eff) ? {4'd0, end_col_reg} : cols_eff;
        c17 = {4'd0, col_pos_reg};
        in_win = (c17 >= {4'd0, first_col_reg}) && (c17 < hi);
        in_ctl.first = (row_pos_reg == 16'd0);
        in_ctl.emit  = (row_pos_reg == rows_eff - 16'd1);
        in_ctl.last  = (c17 == hi - 17'd1);
        in_ctl.col   = col_pos_reg[11:0];
    end

    // elastic handshake, back to front
    always_comb
    begin
        fire_e = ve_reg && (!e_ctl_reg.emit || !vo_reg || result.ready);
        adv_d  = vd_reg && (!ve_reg || fire_e);
        haz    = !c_ctl_reg.first && ((vd_reg && (d_idx_reg == c_idx_reg)) ||
                                      (ve_reg && (e_idx_reg == c_idx_reg)));
        adv_c  = vc_reg && (!vd_reg || adv_d) && !haz;
        adv_b  = vb_reg && (!vc_reg || adv_c);
        adv_a  = va_reg && (!vb_reg || adv_b);
    end

    assign elem.ready = !va_reg || adv_a;
    assign accept     = elem.valid && elem.ready;
    assign accept_win = accept && in_win;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        row_count_next  = row_count_reg;
        total_cols_next = total_cols_reg;
        first_col_next  = first_col_reg;
        end_col_next    = end_col_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                vmwm_pkg::CFG_ROW_COUNT:
                begin
                    row_count_next = cfg.data;
                    row_pos_next = 16'd0;
                    col_pos_next = 13'd0;
                end
                vmwm_pkg::CFG_TOTAL_COLS:
                begin
                    total_cols_next = cfg.data[12:0];
                    row_pos_next = 16'd0;
                    col_pos_next = 13'd0;
                end
                vmwm_pkg::CFG_FIRST_COL:
                begin
                    first_col_next = cfg.data[12:0];
                    row_pos_next = 16'd0;
                    col_pos_next = 13'd0;
                end
                vmwm_pkg::CFG_END_COL:
                begin
                    end_col_next = cfg.data[12:0];
                    row_pos_next = 16'd0;
                    col_pos_next = 13'd0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (c17 + 17'd1 >= cols_eff)
            begin
                col_pos_next = 13'd0;
                row_pos_next = ({1'b0, row_pos_reg} + 17'd1 >= {1'b0, rows_eff}) ?
                               16'd0 : row_pos_reg + 16'd1;
            end
            else
            begin
                col_pos_next = col_pos_reg + 13'd1;
            end
        end
    end

    always_comb
    begin
        va_next = accept_win ? 1'b1 : (adv_a ? 1'b0 : va_reg);
        vb_next = adv_a ? 1'b1 : (adv_b ? 1'b0 : vb_reg);
        vc_next = adv_b ? 1'b1 : (adv_c ? 1'b0 : vc_reg);
        vd_next = adv_c ? 1'b1 : (adv_d ? 1'b0 : vd_reg);
        ve_next = adv_d ? 1'b1 : (fire_e ? 1'b0 : ve_reg);
        if (fire_e && e_ctl_reg.emit)
        begin
            vo_next = 1'b1;
        end
        else if (result.ready)
        begin
            vo_next = 1'b0;
        end
        else
        begin
            vo_next = vo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= 16'd1;
            total_cols_reg <= 13'd1;
            first_col_reg  <= 13'd0;
            end_col_reg    <= 13'd1;
            row_pos_reg    <= 16'd0;
            col_pos_reg    <= 13'd0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            row_count_reg  <= row_count_next;
            total_cols_reg <= total_cols_next;
            first_col_reg  <= first_col_next;
            end_col_reg    <= end_col_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vd_reg <= vd_next;
            ve_reg <= ve_next;
            vo_reg <= vo_next;
        end
    end

    // accumulator operand: row 0 takes the product as is
    always_comb
    begin
        d_add = vmwm_pkg::add_align(ram_rdata, d_prod_reg);
        if (d_ctl_reg.first)
        begin
            d_add.spec = 1'b1;
            d_add.spec_val = d_prod_reg;
        end
        e_sum = vmwm_pkg::add_norm(e_add_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept_win)
        begin
            a_ctl_reg <= in_ctl;
            a_idx_reg <= AW'(col_pos_reg);
            a_mat_reg <= elem.matrix_element;
            a_vec_reg <= elem.vector_element;
        end
        if (adv_a)
        begin
            b_ctl_reg <= a_ctl_reg;
            b_idx_reg <= a_idx_reg;
            b_mul_reg <= vmwm_pkg::mul_pre(a_vec_reg, a_mat_reg);
        end
        if (adv_b)
        begin
            c_ctl_reg <= b_ctl_reg;
            c_idx_reg <= b_idx_reg;
            c_mul_reg <= vmwm_pkg::mul_norm(b_mul_reg);
        end
        if (adv_c)
        begin
            d_ctl_reg  <= c_ctl_reg;
            d_idx_reg  <= c_idx_reg;
            d_prod_reg <= vmwm_pkg::mul_round(c_mul_reg);
        end
        if (adv_d)
        begin
            e_ctl_reg <= d_ctl_reg;
            e_idx_reg <= d_idx_reg;
            e_add_reg <= d_add;
        end
        if (fire_e && e_ctl_reg.emit)
        begin
            o_col_reg  <= e_ctl_reg.col;
            o_val_reg  <= e_sum;
            o_last_reg <= e_ctl_reg.last;
        end
    end

    vmwm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLS)
    ) u_sums (
        .clk   (clk),
        .we    (fire_e),
        .waddr (e_idx_reg),
        .wdata (e_sum),
        .re    (adv_c),
        .raddr (c_idx_reg),
        .rdata (ram_rdata)
    );

    assign result.valid        = vo_reg;
    assign result.column_index = o_col_reg;
    assign result.result_value = o_val_reg;
    assign result.last_column  = o_last_reg;

endmodule

/* hdl/vmwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vmwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
